/* rtl/core/rhc_pkg.sv */
// Package of the RGB to HSV converter: sizes, scale constants and the word
// types that travel between the cells of the divider chain.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rhc_pkg;

  // Channel width and hue resolution (hue in 1/2^HueFracBits degree).
  localparam int ChannelBits = 8;
  localparam int HueFracBits = 6;

  localparam int ChanMax  = (1 << ChannelBits) - 1;
  // Hue units in one 60 degree sector.
  localparam int HueScale = 60 * (1 << HueFracBits);
  // Quotient bits: the hue quotient stays at or below HueScale, below
  // 2^(HueFracBits+6); the saturation quotient stays at or below ChanMax.
  localparam int QuotBits = (ChannelBits > HueFracBits + 6) ? ChannelBits : HueFracBits + 6;
  // Dividend width: the remainder part over the quotient part.
  localparam int DivBits  = ChannelBits + QuotBits;
  // Hue stays below 360 degrees, below 2^(HueFracBits+9).
  localparam int HueBits  = HueFracBits + 9;

  typedef enum logic [1:0] {
    SectorRed,
    SectorGreen,
    SectorBlue
  } sector_e;

  // Input pixel word.
  typedef struct packed {
    logic [ChannelBits-1:0] red_in;
    logic [ChannelBits-1:0] green_in;
    logic [ChannelBits-1:0] blue_in;
    logic [ChannelBits-1:0] alpha_in;
  } rgba_t;

  // Result word.
  typedef struct packed {
    logic [HueBits-1:0]     hue_out;
    logic [ChannelBits-1:0] saturation_out;
    logic [ChannelBits-1:0] value_out;
    logic [ChannelBits-1:0] alpha_out;
    logic                   hue_defined;
  } hsv_t;

  // Word handed from cell to cell: two restoring divisions in flight.
  // The *_dq field starts as the low dividend bits and fills with
  // quotient bits from the right, one per cell.
  typedef struct packed {
    logic [ChannelBits-1:0] sat_rem;
    logic [QuotBits-1:0]    sat_dq;
    logic [ChannelBits-1:0] sat_div;
    logic [ChannelBits-1:0] hue_rem;
    logic [QuotBits-1:0]    hue_dq;
    logic [ChannelBits-1:0] hue_div;
    sector_e                sector;
    logic                   diff_neg;
    logic                   defined;
    logic [ChannelBits-1:0] value;
    logic [ChannelBits-1:0] alpha;
  } work_t;

endpackage

/* rtl/core/rhc_rgba_if.sv */
// Stream interface that carries one RGBA pixel word per handshake.
// Depends on rhc_pkg for the channel width.
`timescale 1ns / 1ps

interface rhc_rgba_if import rhc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ChannelBits-1:0] red_in;
  logic [ChannelBits-1:0] green_in;
  logic [ChannelBits-1:0] blue_in;
  logic [ChannelBits-1:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

/* rtl/core/rhc_hsv_if.sv */
// Stream interface that carries one HSV result word per handshake.
// Depends on rhc_pkg for the field widths.
`timescale 1ns / 1ps

interface rhc_hsv_if import rhc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [HueBits-1:0]     hue_out;
  logic [ChannelBits-1:0] saturation_out;
  logic [ChannelBits-1:0] value_out;
  logic [ChannelBits-1:0] alpha_out;
  logic                   hue_defined;

  modport source (output valid, output hue_out, output saturation_out, output value_out,
                  output alpha_out, output hue_defined, input ready);
  modport sink   (input valid, input hue_out, input saturation_out, input value_out,
                  input alpha_out, input hue_defined, output ready);
endinterface

/* rtl/core/rgb_to_hsv_converter_unit.sv */
// Top level of the RGB to HSV converter: front cell, divider chain of
// identical cells and back cell. Depends on rhc_pkg, rhc_rgba_if,
// rhc_hsv_if, rhc_front, rhc_div_cell and rhc_back.
//
// Usage:
//   rgba_i is a valid/ready sink for pixel words (red, green, blue, alpha);
//   hsv_o is a valid/ready source for result words (hue in 1/64 degree,
//   saturation, value, alpha and the hue_defined flag).
//   One result word leaves for every pixel word taken, in the same order.
// Pipeline and throughput:
//   An accepted pixel word passes through the front cell register, 12 divider
//   cells (one quotient bit each) and the output register.
//   One word per cycle enters while the receiver keeps up.
// Reset:
//   rst_ni clears every valid flag at once; the chain is then empty and
//   ready to take words.
// Stall:
//   While hsv_o.ready is low the output register holds its word. Each cell
//   keeps accepting as long as it or a cell downstream has room, so the
//   chain fills its bubbles before rgba_i.ready drops.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_unit import rhc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  rhc_rgba_if.sink        rgba_i,
  rhc_hsv_if.source       hsv_o
);

  logic  valid_c [QuotBits+1];
  logic  ready_c [QuotBits+1];
  work_t work_c  [QuotBits+1];
  rgba_t pix;
  hsv_t  hsv;

  assign pix.red_in   = rgba_i.red_in;
  assign pix.green_in = rgba_i.green_in;
  assign pix.blue_in  = rgba_i.blue_in;
  assign pix.alpha_in = rgba_i.alpha_in;

  // Sector and dividends.
  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rgba_i.valid),
    .pix_i   (pix),
    .ready_o (rgba_i.ready),
    .valid_o (valid_c[0]),
    .work_o  (work_c[0]),
    .ready_i (ready_c[0])
  );

  // Divider chain, one quotient bit per cell.
  for (genvar i = 0; i < QuotBits; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .work_i  (work_c[i]),
      .ready_o (ready_c[i]),
      .valid_o (valid_c[i+1]),
      .work_o  (work_c[i+1]),
      .ready_i (ready_c[i+1])
    );
  end

  // Hue assembly and output register.
  rhc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[QuotBits]),
    .work_i  (work_c[QuotBits]),
    .ready_o (ready_c[QuotBits]),
    .valid_o (hsv_o.valid),
    .hsv_o   (hsv),
    .ready_i (hsv_o.ready)
  );

  assign hsv_o.hue_out        = hsv.hue_out;
  assign hsv_o.saturation_out = hsv.saturation_out;
  assign hsv_o.value_out      = hsv.value_out;
  assign hsv_o.alpha_out      = hsv.alpha_out;
  assign hsv_o.hue_defined    = hsv.hue_defined;

endmodule

/* rtl/core/rhc_front.sv */
// Front cell of the converter: max, min, sector choice and the two scaled
// dividends that seed the divider chain. Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_front import rhc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  rgba_t pix_i,
  output logic  ready_o,
  output logic  valid_o,
  output work_t work_o,
  input  logic  ready_i
);

  logic                   valid_q;
  work_t                  work_q, work_d;
  logic [ChannelBits-1:0] mx, mn, delta, abs_diff;
  logic [DivBits-1:0]     sat_dvd, hue_dvd;

  // The stage takes a new word when it is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign work_o  = work_q;

  // Extremes, sector and the signed channel difference of that sector.
  always_comb begin
    mx = pix_i.red_in;
    mn = pix_i.red_in;
    if (pix_i.green_in > mx) mx = pix_i.green_in;
    if (pix_i.blue_in > mx) mx = pix_i.blue_in;
    if (pix_i.green_in < mn) mn = pix_i.green_in;
    if (pix_i.blue_in < mn) mn = pix_i.blue_in;
    delta = mx - mn;

    work_d = '0;
    if (pix_i.red_in == mx) begin
      work_d.sector   = SectorRed;
      work_d.diff_neg = pix_i.green_in < pix_i.blue_in;
      abs_diff = work_d.diff_neg ? pix_i.blue_in - pix_i.green_in
                                 : pix_i.green_in - pix_i.blue_in;
    end else if (pix_i.green_in == mx) begin
      work_d.sector   = SectorGreen;
      work_d.diff_neg = pix_i.blue_in < pix_i.red_in;
      abs_diff = work_d.diff_neg ? pix_i.red_in - pix_i.blue_in
                                 : pix_i.blue_in - pix_i.red_in;
    end else begin
      work_d.sector   = SectorBlue;
      work_d.diff_neg = pix_i.red_in < pix_i.green_in;
      abs_diff = work_d.diff_neg ? pix_i.green_in - pix_i.red_in
                                 : pix_i.red_in - pix_i.green_in;
    end

    // Both quotients fit in QuotBits, so the upper dividend bits are
    // already below the divisor and serve as the first remainder.
    sat_dvd = DivBits'(ChanMax) * DivBits'(delta);
    hue_dvd = DivBits'(HueScale) * DivBits'(abs_diff);

    work_d.sat_rem = sat_dvd[DivBits-1:QuotBits];
    work_d.sat_dq  = sat_dvd[QuotBits-1:0];
    work_d.sat_div = mx;
    work_d.hue_rem = hue_dvd[DivBits-1:QuotBits];
    work_d.hue_dq  = hue_dvd[QuotBits-1:0];
    work_d.hue_div = delta;
    work_d.defined = delta != '0;
    work_d.value   = mx;
    work_d.alpha   = pix_i.alpha_in;
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

/* rtl/core/rhc_div_cell.sv */
// One cell of the divider chain: a restoring step for the saturation and
// the hue division, one quotient bit each. Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_div_cell import rhc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  work_t work_i,
  output logic  ready_o,
  output logic  valid_o,
  output work_t work_o,
  input  logic  ready_i
);

  logic                 valid_q;
  work_t                work_q, work_d;
  logic [ChannelBits:0] sat_sh, hue_sh, sat_sub, hue_sub;
  logic                 sat_ge, hue_ge;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign work_o  = work_q;

  // Shift the next dividend bit into each remainder and try the subtract.
  always_comb begin
    work_d  = work_i;
    sat_sh  = {work_i.sat_rem, work_i.sat_dq[QuotBits-1]};
    hue_sh  = {work_i.hue_rem, work_i.hue_dq[QuotBits-1]};
    sat_sub = sat_sh - {1'b0, work_i.sat_div};
    hue_sub = hue_sh - {1'b0, work_i.hue_div};
    sat_ge  = sat_sh >= {1'b0, work_i.sat_div};
    hue_ge  = hue_sh >= {1'b0, work_i.hue_div};

    work_d.sat_rem = sat_ge ? sat_sub[ChannelBits-1:0] : sat_sh[ChannelBits-1:0];
    work_d.sat_dq  = {work_i.sat_dq[QuotBits-2:0], sat_ge};
    work_d.hue_rem = hue_ge ? hue_sub[ChannelBits-1:0] : hue_sh[ChannelBits-1:0];
    work_d.hue_dq  = {work_i.hue_dq[QuotBits-2:0], hue_ge};
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

/* rtl/core/rhc_back.sv */
// Back cell of the converter: signs the hue quotient, adds the sector base,
// wraps negative red hues and holds the result word. Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_back import rhc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  work_t work_i,
  output logic  ready_o,
  output logic  valid_o,
  output hsv_t  hsv_o,
  input  logic  ready_i
);

  logic               valid_q;
  hsv_t               hsv_q, hsv_d;
  logic [HueBits-1:0] quot, base;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign hsv_o   = hsv_q;

  // Hue from sector base and truncated quotient.
  always_comb begin
    quot = HueBits'(work_i.hue_dq);
    case (work_i.sector)
      SectorRed:   base = '0;
      SectorGreen: base = HueBits'(2 * HueScale);
      SectorBlue:  base = HueBits'(4 * HueScale);
      default:     base = '0;
    endcase
    // A negative red hue wraps by one full turn; a zero quotient is not negative.
    if (work_i.sector == SectorRed && work_i.diff_neg && quot != '0) begin
      base = HueBits'(6 * HueScale);
    end

    hsv_d = '0;
    hsv_d.value_out   = work_i.value;
    hsv_d.alpha_out   = work_i.alpha;
    hsv_d.hue_defined = work_i.defined;
    if (work_i.defined) begin
      hsv_d.hue_out        = work_i.diff_neg ? base - quot : base + quot;
      hsv_d.saturation_out = work_i.sat_dq[ChannelBits-1:0];
    end
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Result word.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hsv_q <= hsv_d;
    end
  end

endmodule

/* rtl/core/rhc_checker.sv */
// Port checker of the converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_converter_unit.
`timescale 1ns / 1ps

module rhc_checker import rhc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [HueBits-1:0]     hue_i,
  input logic [ChannelBits-1:0] sat_i,
  input logic [ChannelBits-1:0] value_i,
  input logic [ChannelBits-1:0] alpha_i,
  input logic                   hue_defined_i
);

  // A stalled word stays offered.
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A stalled word keeps its payload.
  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(hue_i) && $stable(sat_i) && $stable(value_i) && $stable(alpha_i)
      && $stable(hue_defined_i))
    else $error("stalled result word changed");

  // Gray pixels carry no hue and no saturation.
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hue_defined_i |-> hue_i == '0 && sat_i == '0)
    else $error("gray pixel with hue or saturation");

  // A colored pixel has a wrapped hue and nonzero value and saturation.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hue_defined_i |-> hue_i < HueBits'(6 * HueScale))
    else $error("hue beyond a full turn");

  a_colored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hue_defined_i |-> value_i != '0 && sat_i != '0)
    else $error("colored pixel with zero value or saturation");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (hsv_o.valid),
  .out_ready_i   (hsv_o.ready),
  .hue_i         (hsv_o.hue_out),
  .sat_i         (hsv_o.saturation_out),
  .value_i       (hsv_o.value_out),
  .alpha_i       (hsv_o.alpha_out),
  .hue_defined_i (hsv_o.hue_defined)
);
